>>> src/lgd_pkg.sv
package lgd_pkg;

    // fixed point and lattice
    localparam int FRAC_BITS = 16;
    localparam int PERIOD    = 10;
    localparam int DEPTH     = PERIOD * PERIOD * PERIOD;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int CELL_W    = $clog2(PERIOD);

    // field widths
    localparam int IDX_W   = 10;
    localparam int GRAD_W  = 8;
    localparam int ENTRY_W = 3 * GRAD_W;
    localparam int PT_W    = 32;
    localparam int DIR_W   = 18;
    localparam int OUT_W   = 18;
    localparam int INT_W   = PT_W - FRAC_BITS;

    // configuration port
    localparam int CFG_W     = 24;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_POSITION_GAIN = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_DISPLACE_GAIN = 1'b1;
    localparam logic [CFG_W-1:0] POSITION_GAIN_RST = CFG_W'(1 << FRAC_BITS);
    localparam logic [CFG_W-1:0] DISPLACE_GAIN_RST = CFG_W'(1 << FRAC_BITS);

    // item kinds
    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    // modulo by the period through a reciprocal, exact for INT_W bit values
    localparam int RECIP_SH = 28;
    localparam longint RECIP = ((longint'(1) << RECIP_SH) + PERIOD - 1) / PERIOD;
    localparam int CELL_OFS = (PERIOD - ((1 << (INT_W - 1)) % PERIOD)) % PERIOD;

    // magnitude that the displaced vector is brought up to before normalising
    localparam int NORM_BIT = 29;

    // iterative units
    localparam int SQ_IN_W   = 64;
    localparam int SQ_OUT_W  = 32;
    localparam int DIV_NUM_W = 48;
    localparam int DIV_DEN_W = 32;
    localparam int DIV_Q_W   = 18;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SCALE,
        ST_SAT,
        ST_CELL_Q,
        ST_CELL_R,
        ST_RD,
        ST_GRAD,
        ST_DSQ,
        ST_SQ_GO,
        ST_SQ_WAIT,
        ST_DIV_WAIT,
        ST_MUL,
        ST_ACC,
        ST_DISP,
        ST_RSUM,
        ST_ZCHK,
        ST_NORM,
        ST_SQR,
        ST_LEN_GO,
        ST_LEN_WAIT,
        ST_ODIV_WAIT,
        ST_EMIT
    } t_state;

endpackage

>>> src/lgd_in_if.sv
interface lgd_in_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 mode;
    logic [lgd_pkg::IDX_W-1:0]            entry_index;
    logic signed [lgd_pkg::GRAD_W-1:0]    grad_x;
    logic signed [lgd_pkg::GRAD_W-1:0]    grad_y;
    logic signed [lgd_pkg::GRAD_W-1:0]    grad_z;
    logic signed [lgd_pkg::PT_W-1:0]      point_x;
    logic signed [lgd_pkg::PT_W-1:0]      point_y;
    logic signed [lgd_pkg::PT_W-1:0]      point_z;
    logic signed [lgd_pkg::DIR_W-1:0]     dir_x;
    logic signed [lgd_pkg::DIR_W-1:0]     dir_y;
    logic signed [lgd_pkg::DIR_W-1:0]     dir_z;

    modport source (
        output valid, mode, entry_index, grad_x, grad_y, grad_z,
               point_x, point_y, point_z, dir_x, dir_y, dir_z,
        input  ready
    );
    modport sink (
        input  valid, mode, entry_index, grad_x, grad_y, grad_z,
               point_x, point_y, point_z, dir_x, dir_y, dir_z,
        output ready
    );
endinterface

>>> src/lgd_out_if.sv
interface lgd_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [lgd_pkg::OUT_W-1:0]  out_x;
    logic signed [lgd_pkg::OUT_W-1:0]  out_y;
    logic signed [lgd_pkg::OUT_W-1:0]  out_z;
    logic                              zero_vector;

    modport source (output valid, out_x, out_y, out_z, zero_vector, input ready);
    modport sink (input valid, out_x, out_y, out_z, zero_vector, output ready);
endinterface

>>> src/lgd_table.sv
module lgd_table (
    input  logic                               i_clk,
    input  logic                               i_we,
    input  logic [lgd_pkg::ADDR_W-1:0]         i_waddr,
    input  logic [lgd_pkg::ENTRY_W-1:0]        i_wdata,
    input  logic                               i_re,
    input  logic [lgd_pkg::ADDR_W-1:0]         i_raddr,
    output logic [lgd_pkg::ENTRY_W-1:0]        o_rdata
);

    logic [lgd_pkg::ENTRY_W-1:0] r_mem [lgd_pkg::DEPTH];
    logic [lgd_pkg::ENTRY_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/lgd_sqrt.sv
module lgd_sqrt (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic [lgd_pkg::SQ_IN_W-1:0]        i_radicand,
    output logic                               o_busy,
    output logic [lgd_pkg::SQ_OUT_W-1:0]       o_root
);

    localparam int REM_W = lgd_pkg::SQ_OUT_W + 4;
    localparam int CNT_W = $clog2(lgd_pkg::SQ_OUT_W);

    logic                              r_busy;
    logic [CNT_W-1:0]                  r_cnt;
    logic [lgd_pkg::SQ_IN_W-1:0]       r_val;
    logic [REM_W-1:0]                  r_rem;
    logic [lgd_pkg::SQ_OUT_W-1:0]      r_root;
    logic [REM_W-1:0]                  c_rem_t;
    logic [REM_W-1:0]                  c_trial;
    logic                              c_ge;

    // one result bit per cycle, two radicand bits shifted in
    always_comb begin
        c_rem_t = {r_rem[REM_W-3:0], r_val[lgd_pkg::SQ_IN_W-1 -: 2]};
        c_trial = {2'b00, r_root, 2'b01};
        c_ge    = (c_rem_t >= c_trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + CNT_W'(1);
            if (r_cnt == CNT_W'(lgd_pkg::SQ_OUT_W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_val  <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_val  <= {r_val[lgd_pkg::SQ_IN_W-3:0], 2'b00};
            r_rem  <= c_ge ? (c_rem_t - c_trial) : c_rem_t;
            r_root <= {r_root[lgd_pkg::SQ_OUT_W-2:0], c_ge};
        end
    end

    assign o_busy = r_busy;
    assign o_root = r_root;

endmodule

>>> src/lgd_div.sv
module lgd_div (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic [lgd_pkg::DIV_NUM_W-1:0]      i_num,
    input  logic [lgd_pkg::DIV_DEN_W-1:0]      i_den,
    output logic                               o_busy,
    output logic [lgd_pkg::DIV_Q_W-1:0]        o_quot
);

    // the quotient is known to fit DIV_Q_W bits, so the top of the
    // numerator starts out below the divisor
    localparam int REM_W = lgd_pkg::DIV_DEN_W + 1;
    localparam int CNT_W = $clog2(lgd_pkg::DIV_Q_W);

    logic                              r_busy;
    logic [CNT_W-1:0]                  r_cnt;
    logic [REM_W-1:0]                  r_rem;
    logic [lgd_pkg::DIV_Q_W-1:0]       r_low;
    logic [lgd_pkg::DIV_DEN_W-1:0]     r_den;
    logic [lgd_pkg::DIV_Q_W-1:0]       r_quot;
    logic [REM_W-1:0]                  c_t;
    logic                              c_ge;

    always_comb begin
        c_t  = {r_rem[REM_W-2:0], r_low[lgd_pkg::DIV_Q_W-1]};
        c_ge = (c_t >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + CNT_W'(1);
            if (r_cnt == CNT_W'(lgd_pkg::DIV_Q_W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= REM_W'(i_num[lgd_pkg::DIV_NUM_W-1:lgd_pkg::DIV_Q_W]);
            r_low  <= i_num[lgd_pkg::DIV_Q_W-1:0];
            r_den  <= i_den;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= c_ge ? (c_t - {1'b0, r_den}) : c_t;
            r_low  <= {r_low[lgd_pkg::DIV_Q_W-2:0], 1'b0};
            r_quot <= {r_quot[lgd_pkg::DIV_Q_W-2:0], c_ge};
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_quot;

endmodule

>>> src/lattice_gradient_displace.sv
// Gradient-noise displacement of a direction vector. A load word (mode 0)
// writes one 24 bit gradient {z,y,x} into a 10x10x10 periodic table; an
// index of 1000 or more is dropped. A query word (mode 1) scales
// its point by position_gain, finds the lattice cell, and sums the unit
// gradients of the 8 cell corners weighted by max(0, 1 - distance). The sum is
// scaled by displace_gain, added to the direction, and normalised to unit
// length in Q1.16; a zero vector gives zero and sets zero_vector. A query
// first scales its point and finds the cell, then reads the table once per
// corner; a corner with a non-zero gradient runs a 32 step square root for
// gradient length and distance side by side, then an 18 step divide per
// axis, and a corner with a zero gradient adds nothing. The displacement is
// then scaled and added, and the final normalisation takes up to 29 shift
// steps, one more square root and one more divide. The table is a single-port-read
// memory, one corner per read. Entries never written read back as anything.
// Gains are to be written only while the block is idle; the block does not
// enforce this. A new word is taken while a result still waits.
module lattice_gradient_displace (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [lgd_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [lgd_pkg::CFG_W-1:0]           i_cfg_data,
    lgd_in_if.sink                              i_item,
    lgd_out_if.source                           o_result
);

    localparam int PROD_W = lgd_pkg::PT_W + lgd_pkg::CFG_W + 1;
    localparam int SH_W   = PROD_W - lgd_pkg::FRAC_BITS;
    localparam int QP_W   = lgd_pkg::INT_W + lgd_pkg::RECIP_SH;
    localparam int CO_W   = lgd_pkg::CELL_W + 1;
    localparam int GS_W   = 2 * lgd_pkg::GRAD_W;
    localparam int DD_W   = lgd_pkg::FRAC_BITS + 2;
    localparam int DSQ_W  = 2 * lgd_pkg::FRAC_BITS + 2;
    localparam int W_W    = lgd_pkg::FRAC_BITS + 1;
    localparam int N_W    = lgd_pkg::DIV_Q_W + 1;
    localparam int NW_W   = N_W + W_W + 1;
    localparam int SUM_W  = 24;
    localparam int DP_W   = SUM_W + lgd_pkg::CFG_W;
    localparam int RSQ_W  = 2 * (lgd_pkg::PT_W - 1);

    // control
    lgd_pkg::t_state r_state, n_state;
    logic [2:0]      r_corner;
    logic            r_ovalid;

    // configuration
    logic [lgd_pkg::CFG_W-1:0]         r_pgain;
    logic signed [lgd_pkg::CFG_W-1:0]  r_dgain;

    // per-axis datapath
    logic signed [lgd_pkg::PT_W-1:0]   r_pt    [3];
    logic signed [lgd_pkg::DIR_W-1:0]  r_dir   [3];
    logic signed [PROD_W-1:0]          r_sprod [3];
    logic [lgd_pkg::FRAC_BITS-1:0]     r_frac  [3];
    logic [lgd_pkg::INT_W-1:0]         r_u     [3];
    logic [lgd_pkg::INT_W-1:0]         r_q     [3];
    logic [lgd_pkg::CELL_W-1:0]        r_cell  [3];
    logic signed [lgd_pkg::GRAD_W-1:0] r_g     [3];
    logic signed [DD_W-1:0]            r_dd    [3];
    logic [DSQ_W-1:0]                  r_dsq   [3];
    logic                              r_neg   [3];
    logic signed [NW_W-1:0]            r_nw    [3];
    logic signed [SUM_W-1:0]           r_sum   [3];
    logic signed [DP_W-1:0]            r_dprod [3];
    logic signed [lgd_pkg::PT_W-1:0]   r_r     [3];
    logic [RSQ_W-1:0]                  r_rsq   [3];
    logic signed [lgd_pkg::OUT_W-1:0]  r_res   [3];
    logic [GS_W-1:0]                   r_gs;
    logic [W_W-1:0]                    r_w;
    logic                              r_zero;

    // output register
    logic signed [lgd_pkg::OUT_W-1:0]  r_out   [3];
    logic                              r_ozero;

    // combinational
    logic                              c_accept;
    logic                              c_in_ready;
    logic                              c_mem_re;
    logic                              c_sq_start;
    logic                              c_len_start;
    logic                              c_div_start;
    logic                              c_emit;
    logic                              c_last;
    logic                              c_all_zero;
    logic                              c_small;
    logic                              c_div_busy;
    logic [lgd_pkg::PT_W-1:0]          c_s     [3];
    logic [lgd_pkg::INT_W-1:0]         c_qn    [3];
    logic [lgd_pkg::CELL_W-1:0]        c_celln [3];
    logic [CO_W-1:0]                   c_co    [3];
    logic signed [lgd_pkg::GRAD_W-1:0] c_gv    [3];
    logic signed [DD_W-1:0]            c_ddn   [3];
    logic [GS_W-1:0]                   c_gs;
    logic [lgd_pkg::ADDR_W-1:0]        c_raddr;
    logic [lgd_pkg::ENTRY_W-1:0]       c_rdata;
    logic                              c_we;
    logic [lgd_pkg::SQ_IN_W-1:0]       c_rad_a;
    logic [lgd_pkg::SQ_IN_W-1:0]       c_rad_b;
    logic                              c_sqa_busy, c_sqb_busy;
    logic [lgd_pkg::SQ_OUT_W-1:0]      c_root_a, c_root_b;
    logic [W_W-1:0]                    c_w;
    logic [lgd_pkg::DIV_NUM_W-1:0]     c_num   [3];
    logic [lgd_pkg::DIV_Q_W-1:0]       c_quot  [3];
    logic                              c_dbusy [3];
    logic signed [N_W-1:0]             c_n     [3];
    logic                              c_negn  [3];

    assign c_accept = i_item.valid && c_in_ready;
    assign c_we     = c_accept && (i_item.mode == lgd_pkg::MODE_LOAD)
                      && (i_item.entry_index < lgd_pkg::IDX_W'(lgd_pkg::DEPTH));
    assign c_last   = (r_corner == 3'd7);
    assign c_div_busy = c_dbusy[0] || c_dbusy[1] || c_dbusy[2];

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pgain <= lgd_pkg::POSITION_GAIN_RST;
            r_dgain <= lgd_pkg::DISPLACE_GAIN_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                lgd_pkg::REG_POSITION_GAIN: r_pgain <= i_cfg_data;
                lgd_pkg::REG_DISPLACE_GAIN: r_dgain <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // lane arithmetic
    always_comb begin
        logic signed [SH_W-1:0]    sh;
        logic [QP_W-1:0]           qp;
        logic [lgd_pkg::INT_W-1:0] m;
        logic [CO_W-1:0]           md;
        logic                      cbit;
        c_all_zero = 1'b1;
        c_small    = 1'b1;
        c_gs       = '0;
        c_w = (c_root_b >= lgd_pkg::SQ_OUT_W'(1 << lgd_pkg::FRAC_BITS)) ? '0 :
              W_W'(lgd_pkg::SQ_OUT_W'(1 << lgd_pkg::FRAC_BITS) - c_root_b);
        for (int a = 0; a < 3; a++) begin
            // saturate the scaled point to 32 bits
            sh = r_sprod[a][PROD_W-1:lgd_pkg::FRAC_BITS];
            if ((&sh[SH_W-1:lgd_pkg::PT_W-1]) || !(|sh[SH_W-1:lgd_pkg::PT_W-1])) begin
                c_s[a] = sh[lgd_pkg::PT_W-1:0];
            end else if (sh[SH_W-1]) begin
                c_s[a] = {1'b1, {(lgd_pkg::PT_W-1){1'b0}}};
            end else begin
                c_s[a] = {1'b0, {(lgd_pkg::PT_W-1){1'b1}}};
            end
            // integer part biased to unsigned, modulo through reciprocal
            qp = QP_W'(r_u[a]) * QP_W'(lgd_pkg::RECIP);
            c_qn[a] = qp[QP_W-1:lgd_pkg::RECIP_SH];
            m = r_u[a] - lgd_pkg::INT_W'(r_q[a] * lgd_pkg::INT_W'(lgd_pkg::PERIOD));
            md = CO_W'(m) + CO_W'(lgd_pkg::CELL_OFS);
            if (md >= CO_W'(lgd_pkg::PERIOD)) begin
                md = md - CO_W'(lgd_pkg::PERIOD);
            end
            c_celln[a] = md[lgd_pkg::CELL_W-1:0];
            // corner coordinate, x follows the top corner bit
            cbit = r_corner[2-a];
            c_co[a] = CO_W'(r_cell[a]) + CO_W'(cbit);
            if (c_co[a] == CO_W'(lgd_pkg::PERIOD)) begin
                c_co[a] = '0;
            end
            c_gv[a] = c_rdata[a*lgd_pkg::GRAD_W +: lgd_pkg::GRAD_W];
            c_gs = c_gs + $unsigned(GS_W'(c_gv[a]) * GS_W'(c_gv[a]));
            c_ddn[a] = $signed({2'b00, r_frac[a]});
            if (cbit) begin
                c_ddn[a] = c_ddn[a] - DD_W'(1 << lgd_pkg::FRAC_BITS);
            end
            // divider numerators: gradient phase or output phase
            if (r_state == lgd_pkg::ST_SQ_WAIT) begin
                c_negn[a] = r_g[a][lgd_pkg::GRAD_W-1];
                c_num[a] = lgd_pkg::DIV_NUM_W'($unsigned(c_negn[a] ?
                                                          lgd_pkg::GRAD_W'(-r_g[a]) :
                                                          lgd_pkg::GRAD_W'(r_g[a])))
                           << (lgd_pkg::FRAC_BITS + 8);
            end else begin
                c_negn[a] = r_r[a][lgd_pkg::PT_W-1];
                c_num[a] = lgd_pkg::DIV_NUM_W'(c_negn[a] ? lgd_pkg::PT_W'(-r_r[a]) :
                                                           lgd_pkg::PT_W'(r_r[a]))
                           << lgd_pkg::FRAC_BITS;
            end
            c_n[a] = r_neg[a] ? -$signed(N_W'(c_quot[a])) : $signed(N_W'(c_quot[a]));
            if (r_r[a] != '0) begin
                c_all_zero = 1'b0;
            end
            if ((r_r[a] >= lgd_pkg::PT_W'(1 << lgd_pkg::NORM_BIT))
                || (r_r[a] <= -lgd_pkg::PT_W'(1 << lgd_pkg::NORM_BIT))) begin
                c_small = 1'b0;
            end
        end
        c_raddr = lgd_pkg::ADDR_W'(c_co[0])
                + lgd_pkg::ADDR_W'(lgd_pkg::PERIOD) * lgd_pkg::ADDR_W'(c_co[1])
                + lgd_pkg::ADDR_W'(lgd_pkg::PERIOD * lgd_pkg::PERIOD)
                  * lgd_pkg::ADDR_W'(c_co[2]);
        c_rad_a = (r_state == lgd_pkg::ST_SQ_GO) ?
                  (lgd_pkg::SQ_IN_W'(r_gs) << lgd_pkg::FRAC_BITS) :
                  (lgd_pkg::SQ_IN_W'(r_rsq[0]) + lgd_pkg::SQ_IN_W'(r_rsq[1])
                   + lgd_pkg::SQ_IN_W'(r_rsq[2]));
        c_rad_b = lgd_pkg::SQ_IN_W'(r_dsq[0]) + lgd_pkg::SQ_IN_W'(r_dsq[1])
                + lgd_pkg::SQ_IN_W'(r_dsq[2]);
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lgd_pkg::ST_IDLE: begin
                if (c_accept && (i_item.mode == lgd_pkg::MODE_QUERY)) begin
                    n_state = lgd_pkg::ST_SCALE;
                end
            end
            lgd_pkg::ST_SCALE:  n_state = lgd_pkg::ST_SAT;
            lgd_pkg::ST_SAT:    n_state = lgd_pkg::ST_CELL_Q;
            lgd_pkg::ST_CELL_Q: n_state = lgd_pkg::ST_CELL_R;
            lgd_pkg::ST_CELL_R: n_state = lgd_pkg::ST_RD;
            lgd_pkg::ST_RD:     n_state = lgd_pkg::ST_GRAD;
            lgd_pkg::ST_GRAD:   n_state = lgd_pkg::ST_DSQ;
            lgd_pkg::ST_DSQ: begin
                if (r_gs != '0) begin
                    n_state = lgd_pkg::ST_SQ_GO;
                end else if (c_last) begin
                    n_state = lgd_pkg::ST_DISP;
                end else begin
                    n_state = lgd_pkg::ST_RD;
                end
            end
            lgd_pkg::ST_SQ_GO: n_state = lgd_pkg::ST_SQ_WAIT;
            lgd_pkg::ST_SQ_WAIT: begin
                if (!c_sqa_busy && !c_sqb_busy) begin
                    n_state = lgd_pkg::ST_DIV_WAIT;
                end
            end
            lgd_pkg::ST_DIV_WAIT: begin
                if (!c_div_busy) begin
                    n_state = lgd_pkg::ST_MUL;
                end
            end
            lgd_pkg::ST_MUL: n_state = lgd_pkg::ST_ACC;
            lgd_pkg::ST_ACC: n_state = c_last ? lgd_pkg::ST_DISP : lgd_pkg::ST_RD;
            lgd_pkg::ST_DISP: n_state = lgd_pkg::ST_RSUM;
            lgd_pkg::ST_RSUM: n_state = lgd_pkg::ST_ZCHK;
            lgd_pkg::ST_ZCHK: n_state = c_all_zero ? lgd_pkg::ST_EMIT : lgd_pkg::ST_NORM;
            lgd_pkg::ST_NORM: begin
                if (!c_small) begin
                    n_state = lgd_pkg::ST_SQR;
                end
            end
            lgd_pkg::ST_SQR:    n_state = lgd_pkg::ST_LEN_GO;
            lgd_pkg::ST_LEN_GO: n_state = lgd_pkg::ST_LEN_WAIT;
            lgd_pkg::ST_LEN_WAIT: begin
                if (!c_sqa_busy) begin
                    n_state = lgd_pkg::ST_ODIV_WAIT;
                end
            end
            lgd_pkg::ST_ODIV_WAIT: begin
                if (!c_div_busy) begin
                    n_state = lgd_pkg::ST_EMIT;
                end
            end
            lgd_pkg::ST_EMIT: begin
                if (!r_ovalid || o_result.ready) begin
                    n_state = lgd_pkg::ST_IDLE;
                end
            end
            default: n_state = lgd_pkg::ST_IDLE;
        endcase
    end

    // control strobes
    always_comb begin
        c_in_ready  = 1'b0;
        c_mem_re    = 1'b0;
        c_sq_start  = 1'b0;
        c_len_start = 1'b0;
        c_div_start = 1'b0;
        c_emit      = 1'b0;
        unique case (r_state)
            lgd_pkg::ST_IDLE:      c_in_ready  = 1'b1;
            lgd_pkg::ST_RD:        c_mem_re    = 1'b1;
            lgd_pkg::ST_SQ_GO:     c_sq_start  = 1'b1;
            lgd_pkg::ST_SQ_WAIT:   c_div_start = !c_sqa_busy && !c_sqb_busy;
            lgd_pkg::ST_LEN_GO:    c_len_start = 1'b1;
            lgd_pkg::ST_LEN_WAIT:  c_div_start = !c_sqa_busy;
            lgd_pkg::ST_EMIT:      c_emit      = !r_ovalid || o_result.ready;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lgd_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // corner counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_corner <= '0;
        end else if (r_state == lgd_pkg::ST_CELL_R) begin
            r_corner <= '0;
        end else if ((r_state == lgd_pkg::ST_ACC)
                     || ((r_state == lgd_pkg::ST_DSQ) && (r_gs == '0))) begin
            r_corner <= r_corner + 3'd1;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            lgd_pkg::ST_IDLE: begin
                r_pt[0]  <= i_item.point_x;
                r_pt[1]  <= i_item.point_y;
                r_pt[2]  <= i_item.point_z;
                r_dir[0] <= i_item.dir_x;
                r_dir[1] <= i_item.dir_y;
                r_dir[2] <= i_item.dir_z;
            end
            lgd_pkg::ST_SCALE: begin
                for (int a = 0; a < 3; a++) begin
                    r_sprod[a] <= r_pt[a] * $signed({1'b0, r_pgain});
                end
            end
            lgd_pkg::ST_SAT: begin
                for (int a = 0; a < 3; a++) begin
                    r_frac[a] <= c_s[a][lgd_pkg::FRAC_BITS-1:0];
                    // cell plus half range: flip the sign bit
                    r_u[a] <= {~c_s[a][lgd_pkg::PT_W-1],
                               c_s[a][lgd_pkg::PT_W-2:lgd_pkg::FRAC_BITS]};
                end
            end
            lgd_pkg::ST_CELL_Q: begin
                for (int a = 0; a < 3; a++) begin
                    r_q[a] <= c_qn[a];
                end
            end
            lgd_pkg::ST_CELL_R: begin
                for (int a = 0; a < 3; a++) begin
                    r_cell[a] <= c_celln[a];
                    r_sum[a]  <= '0;
                end
            end
            lgd_pkg::ST_GRAD: begin
                r_gs <= c_gs;
                for (int a = 0; a < 3; a++) begin
                    r_g[a]  <= c_gv[a];
                    r_dd[a] <= c_ddn[a];
                end
            end
            lgd_pkg::ST_DSQ: begin
                for (int a = 0; a < 3; a++) begin
                    r_dsq[a] <= $unsigned(DSQ_W'(r_dd[a]) * DSQ_W'(r_dd[a]));
                end
            end
            lgd_pkg::ST_SQ_WAIT: begin
                r_w <= c_w;
                for (int a = 0; a < 3; a++) begin
                    r_neg[a] <= c_negn[a];
                end
            end
            lgd_pkg::ST_MUL: begin
                for (int a = 0; a < 3; a++) begin
                    r_nw[a] <= c_n[a] * $signed({1'b0, r_w});
                end
            end
            lgd_pkg::ST_ACC: begin
                for (int a = 0; a < 3; a++) begin
                    r_sum[a] <= r_sum[a] + SUM_W'(r_nw[a] >>> lgd_pkg::FRAC_BITS);
                end
            end
            lgd_pkg::ST_DISP: begin
                for (int a = 0; a < 3; a++) begin
                    r_dprod[a] <= r_sum[a] * r_dgain;
                end
            end
            lgd_pkg::ST_RSUM: begin
                for (int a = 0; a < 3; a++) begin
                    r_r[a] <= lgd_pkg::PT_W'(r_dprod[a] >>> lgd_pkg::FRAC_BITS)
                            + lgd_pkg::PT_W'(r_dir[a]);
                end
            end
            lgd_pkg::ST_ZCHK: begin
                r_zero <= c_all_zero;
                for (int a = 0; a < 3; a++) begin
                    r_res[a] <= '0;
                end
            end
            lgd_pkg::ST_NORM: begin
                if (c_small) begin
                    for (int a = 0; a < 3; a++) begin
                        r_r[a] <= r_r[a] <<< 1;
                    end
                end
            end
            lgd_pkg::ST_SQR: begin
                for (int a = 0; a < 3; a++) begin
                    r_rsq[a] <= $unsigned(RSQ_W'(r_r[a]) * RSQ_W'(r_r[a]));
                end
            end
            lgd_pkg::ST_LEN_WAIT: begin
                for (int a = 0; a < 3; a++) begin
                    r_neg[a] <= c_negn[a];
                end
            end
            lgd_pkg::ST_ODIV_WAIT: begin
                for (int a = 0; a < 3; a++) begin
                    r_res[a] <= lgd_pkg::OUT_W'(c_n[a]);
                end
            end
            default: ;
        endcase
    end

    // output register, parts the result side from the input side
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (c_emit) begin
            r_ovalid <= 1'b1;
        end else if (o_result.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_emit) begin
            r_ozero <= r_zero;
            for (int a = 0; a < 3; a++) begin
                r_out[a] <= r_res[a];
            end
        end
    end

    assign i_item.ready         = c_in_ready;
    assign o_result.valid       = r_ovalid;
    assign o_result.out_x       = r_out[0];
    assign o_result.out_y       = r_out[1];
    assign o_result.out_z       = r_out[2];
    assign o_result.zero_vector = r_ozero;

    // gradient table
    lgd_table u_table (
        .i_clk   (i_clk),
        .i_we    (c_we),
        .i_waddr (lgd_pkg::ADDR_W'(i_item.entry_index)),
        .i_wdata ({i_item.grad_z, i_item.grad_y, i_item.grad_x}),
        .i_re    (c_mem_re),
        .i_raddr (c_raddr),
        .o_rdata (c_rdata)
    );

    // gradient length, then vector length
    lgd_sqrt u_sqrt_a (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (c_sq_start || c_len_start),
        .i_radicand (c_rad_a),
        .o_busy     (c_sqa_busy),
        .o_root     (c_root_a)
    );

    // distance to corner
    lgd_sqrt u_sqrt_b (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (c_sq_start),
        .i_radicand (c_rad_b),
        .o_busy     (c_sqb_busy),
        .o_root     (c_root_b)
    );

    // one divider per axis, shared between normalising gradients and output
    for (genvar a = 0; a < 3; a++) begin : g_div
        lgd_div u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_start (c_div_start),
            .i_num   (c_num[a]),
            .i_den   (c_root_a),
            .o_busy  (c_dbusy[a]),
            .o_quot  (c_quot[a])
        );
    end

endmodule

>>> sim/lgd_checker.sv
module lgd_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [lgd_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [lgd_pkg::CFG_W-1:0]       i_cfg_data,
    lgd_in_if                               i_item,
    lgd_out_if                              i_result,
    output int                              o_fail_count,
    output int                              o_pending
);
    import lgd_pkg::*;

    typedef struct {
        logic signed [OUT_W-1:0] x;
        logic signed [OUT_W-1:0] y;
        logic signed [OUT_W-1:0] z;
        logic                    zero;
    } t_dirn;

    logic [ENTRY_W-1:0] grad_mirror [DEPTH];
    logic [CFG_W-1:0]   pos_gain;
    longint             disp_gain;
    t_dirn              dirn_q [$];

    function automatic longint unsigned sqrt_floor(longint unsigned v);
        longint unsigned res, bits;
        res  = 0;
        bits = 64'd1 << 62;
        while (bits > v) bits >>= 2;
        while (bits != 0) begin
            if (v >= res + bits) begin
                v   -= res + bits;
                res = (res >> 1) + bits;
            end else begin
                res >>= 1;
            end
            bits >>= 2;
        end
        return res;
    endfunction

    function automatic t_dirn displace(input longint pt[3], input longint dv[3]);
        longint s, c, dx, dy, dz, w, n, m, g[3], fr[3], lat_c[3], acc[3], r[3];
        longint unsigned gs, glen, dlen, len;
        logic [ENTRY_W-1:0] e;
        longint ix;
        t_dirn o;
        acc = '{0, 0, 0};
        for (int a = 0; a < 3; a++) begin
            s = (pt[a] * longint'({40'd0, pos_gain})) >>> FRAC_BITS;
            if (s > 64'sd2147483647) s = 64'sd2147483647;
            if (s < -64'sd2147483648) s = -64'sd2147483648;
            fr[a] = s & ((64'sd1 << FRAC_BITS) - 1);
            c = (s >>> FRAC_BITS) % PERIOD;
            if (c < 0) c += PERIOD;
            lat_c[a] = c;
        end
        for (int cx = 0; cx < 2; cx++)
        for (int cy = 0; cy < 2; cy++)
        for (int cz = 0; cz < 2; cz++) begin
            ix = ((lat_c[0] + cx) % PERIOD) + PERIOD * ((lat_c[1] + cy) % PERIOD)
               + PERIOD * PERIOD * ((lat_c[2] + cz) % PERIOD);
            e = grad_mirror[ix];
            g[0] = longint'($signed(e[7:0]));
            g[1] = longint'($signed(e[15:8]));
            g[2] = longint'($signed(e[23:16]));
            gs = g[0] * g[0] + g[1] * g[1] + g[2] * g[2];
            if (gs == 0) continue;  // zero gradient adds nothing
            glen = sqrt_floor(gs << 16);
            dx = cx ? fr[0] - (64'sd1 << FRAC_BITS) : fr[0];
            dy = cy ? fr[1] - (64'sd1 << FRAC_BITS) : fr[1];
            dz = cz ? fr[2] - (64'sd1 << FRAC_BITS) : fr[2];
            dlen = sqrt_floor(dx * dx + dy * dy + dz * dz);
            w = (longint'(dlen) >= (64'sd1 << FRAC_BITS)) ? 0
                : (64'sd1 << FRAC_BITS) - longint'(dlen);
            for (int a = 0; a < 3; a++) begin
                n = (g[a] * (64'sd1 << (FRAC_BITS + 8))) / longint'(glen);
                acc[a] += (n * w) >>> FRAC_BITS;
            end
        end
        for (int a = 0; a < 3; a++)
            r[a] = dv[a] + ((acc[a] * disp_gain) >>> FRAC_BITS);
        if (r[0] == 0 && r[1] == 0 && r[2] == 0) begin
            o.x = '0; o.y = '0; o.z = '0; o.zero = 1'b1;
            return o;
        end
        m = 0;
        for (int a = 0; a < 3; a++)
            if ((r[a] < 0 ? -r[a] : r[a]) > m) m = r[a] < 0 ? -r[a] : r[a];
        while (m >= (64'sd1 << 30)) begin
            for (int a = 0; a < 3; a++) r[a] = r[a] >>> 1;
            m >>= 1;
        end
        while (m < (64'sd1 << NORM_BIT)) begin
            for (int a = 0; a < 3; a++) r[a] *= 2;
            m *= 2;
        end
        len = sqrt_floor(r[0] * r[0] + r[1] * r[1] + r[2] * r[2]);
        o.x = OUT_W'((r[0] * (64'sd1 << FRAC_BITS)) / longint'(len));
        o.y = OUT_W'((r[1] * (64'sd1 << FRAC_BITS)) / longint'(len));
        o.z = OUT_W'((r[2] * (64'sd1 << FRAC_BITS)) / longint'(len));
        o.zero = 1'b0;
        return o;
    endfunction

    always @(posedge i_clk) begin
        t_dirn  want;
        longint pt[3], dv[3];
        int     errs;
        errs = 0;
        if (!i_rst_n) begin
            pos_gain  <= POSITION_GAIN_RST;
            disp_gain <= 65536;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == REG_POSITION_GAIN) pos_gain <= i_cfg_data;
                else if (i_cfg_index == REG_DISPLACE_GAIN)
                    disp_gain <= longint'($signed(i_cfg_data));
            end
            if (i_result.valid && i_result.ready) begin
                if (dirn_q.size() == 0) begin
                    $error("result word with nothing expected");
                    errs++;
                end else begin
                    want = dirn_q.pop_front();
                    if (i_result.out_x !== want.x) begin
                        $error("out_x exp %0d got %0d", want.x, i_result.out_x);
                        errs++;
                    end
                    if (i_result.out_y !== want.y) begin
                        $error("out_y exp %0d got %0d", want.y, i_result.out_y);
                        errs++;
                    end
                    if (i_result.out_z !== want.z) begin
                        $error("out_z exp %0d got %0d", want.z, i_result.out_z);
                        errs++;
                    end
                    if (i_result.zero_vector !== want.zero) begin
                        $error("zero_vector exp %0d got %0d", want.zero,
                               i_result.zero_vector);
                        errs++;
                    end
                end
            end
            if (i_item.valid && i_item.ready) begin
                if (i_item.mode == MODE_QUERY) begin
                    pt = '{longint'(i_item.point_x), longint'(i_item.point_y),
                           longint'(i_item.point_z)};
                    dv = '{longint'(i_item.dir_x), longint'(i_item.dir_y),
                           longint'(i_item.dir_z)};
                    dirn_q.push_back(displace(pt, dv));
                end else if (i_item.entry_index < DEPTH) begin
                    grad_mirror[i_item.entry_index] <=
                        {i_item.grad_z, i_item.grad_y, i_item.grad_x};
                end
            end
            if (errs != 0) o_fail_count <= o_fail_count + errs;
        end
        o_pending <= dirn_q.size();
    end

    initial o_fail_count = 0;
    initial o_pending = 0;
endmodule

>>> sim/tb_lattice_gradient_displace.sv
module tb_lattice_gradient_displace;
    import lgd_pkg::*;

    // cycles with no word moving before the run is declared hung
    localparam int STALL_LIMIT = 20000;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;

    lgd_in_if  item_ch ();
    lgd_out_if res_ch ();

    int fail_count;
    int pending;
    bit idle_on;     // random gaps on both sides
    bit hold_req;    // ask the receiver for one long hold-off
    bit hold_taken;
    int quiet_cycles;

    lattice_gradient_displace DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_item      (item_ch),
        .o_result    (res_ch)
    );

    lgd_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_item       (item_ch),
        .i_result     (res_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // one word onto the item channel, called at a falling edge
    task automatic send_word(input logic md, input logic [IDX_W-1:0] idx,
                             input logic signed [GRAD_W-1:0] gx, gy, gz,
                             input logic signed [PT_W-1:0] px, py, pz,
                             input logic signed [DIR_W-1:0] dx, dy, dz);
        item_ch.valid       <= 1'b1;
        item_ch.mode        <= md;
        item_ch.entry_index <= idx;
        item_ch.grad_x      <= gx;
        item_ch.grad_y      <= gy;
        item_ch.grad_z      <= gz;
        item_ch.point_x     <= px;
        item_ch.point_y     <= py;
        item_ch.point_z     <= pz;
        item_ch.dir_x       <= dx;
        item_ch.dir_y       <= dy;
        item_ch.dir_z       <= dz;
        do @(posedge i_clk); while (!item_ch.ready);
        @(negedge i_clk);
        // sender gap: valid dropped for a burst
        if (idle_on && $urandom_range(0, 5) == 0) begin
            item_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge i_clk);
        end
    endtask

    task automatic load_entry(input int idx, input int gx, gy, gz);
        send_word(MODE_LOAD, IDX_W'(idx), GRAD_W'(gx), GRAD_W'(gy), GRAD_W'(gz),
                  PT_W'($urandom), PT_W'($urandom), PT_W'($urandom),
                  DIR_W'($urandom), DIR_W'($urandom), DIR_W'($urandom));
    endtask

    task automatic query(input logic signed [PT_W-1:0] px, py, pz,
                         input logic signed [DIR_W-1:0] dx, dy, dz);
        send_word(MODE_QUERY, IDX_W'($urandom), GRAD_W'($urandom), GRAD_W'($urandom),
                  GRAD_W'($urandom), px, py, pz, dx, dy, dz);
    endtask

    function automatic int rand_grad();
        return $urandom_range(0, 199) - 100;
    endfunction

    // mostly points near the lattice, now and then anywhere in range
    function automatic logic signed [PT_W-1:0] rand_point();
        if ($urandom_range(0, 3) == 0) return PT_W'($urandom);
        return PT_W'(int'($urandom_range(0, 40 << FRAC_BITS)) - (20 << FRAC_BITS));
    endfunction

    function automatic logic signed [DIR_W-1:0] rand_dir();
        if ($urandom_range(0, 15) == 0) return '0;
        return DIR_W'($urandom);
    endfunction

    // gains change only with nothing in flight; loads leave no result, so
    // a wait after the last result covers one that may still be completing
    task automatic write_gains(input logic [CFG_W-1:0] pg, dg);
        item_ch.valid <= 1'b0;
        wait (pending == 0);
        repeat (20) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_POSITION_GAIN;
        i_cfg_data  <= pg;
        @(negedge i_clk);
        i_cfg_index <= REG_DISPLACE_GAIN;
        i_cfg_data  <= dg;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic random_phase(input int n_words);
        repeat (n_words) begin
            if ($urandom_range(0, 9) < 6)
                query(rand_point(), rand_point(), rand_point(),
                      rand_dir(), rand_dir(), rand_dir());
            else if ($urandom_range(0, 9) == 0)
                // index past the table: dropped by the block
                load_entry($urandom_range(DEPTH, 1023), rand_grad(), rand_grad(),
                           rand_grad());
            else if ($urandom_range(0, 7) == 0)
                load_entry($urandom_range(0, DEPTH - 1), 0, 0, 0);
            else
                load_entry($urandom_range(0, DEPTH - 1), rand_grad(), rand_grad(),
                           rand_grad());
        end
    endtask

    // receiver: random hold-off bursts, plus one long hold-off on request
    initial begin
        res_ch.ready = 1'b0;
        hold_taken   = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                res_ch.ready <= 1'b0;
                repeat (1500) @(negedge i_clk);
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(0, 15)) @(negedge i_clk);
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    // watchdog on words moving through either channel
    initial begin
        quiet_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready)
                || i_cfg_we)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = REG_POSITION_GAIN;
        i_cfg_data  = '0;
        idle_on     = 1'b1;
        hold_req    = 1'b0;
        item_ch.valid       = 1'b0;
        item_ch.mode        = MODE_LOAD;
        item_ch.entry_index = '0;
        item_ch.grad_x      = '0;
        item_ch.grad_y      = '0;
        item_ch.grad_z      = '0;
        item_ch.point_x     = '0;
        item_ch.point_y     = '0;
        item_ch.point_z     = '0;
        item_ch.dir_x       = '0;
        item_ch.dir_y       = '0;
        item_ch.dir_z       = '0;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        write_gains(POSITION_GAIN_RST, DISPLACE_GAIN_RST);

        // fill the whole table so that no query reads an unwritten entry;
        // component extremes and some zero gradients among them
        for (int i = 0; i < DEPTH; i++) begin
            case (i % 16)
                0:       load_entry(i, 0, 0, 0);
                1:       load_entry(i, -100, 99, -100);
                2:       load_entry(i, 99, -100, 99);
                default: load_entry(i, rand_grad(), rand_grad(), rand_grad());
            endcase
        end

        // directed: point extremes, cell wrap below zero, corners exactly on
        // the lattice, dropped load, zero vector
        query(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 18'sh1ffff, 18'sh1ffff,
              18'sh1ffff);
        query(32'sh80000000, 32'sh80000000, 32'sh80000000, 18'sh20000, 18'sh20000,
              18'sh20000);
        query(-32'sd1000 <<< FRAC_BITS, -32'sd1, 32'sd0, 18'sd0, 18'sd1, -18'sd1);
        query(32'sd3 <<< FRAC_BITS, 32'sd7 <<< FRAC_BITS, 32'sd9 <<< FRAC_BITS,
              18'sd65536, 18'sd0, 18'sd0);
        query(32'sd32768, 32'sd32768, 32'sd32768, 18'sd0, 18'sd0, 18'sd0);
        load_entry(1023, 5, 5, 5);
        load_entry(DEPTH, -100, -100, -100);
        load_entry(0, -100, -100, -100);
        load_entry(999, 99, 99, 99);
        query(32'sd0, 32'sd0, 32'sd0, 18'sd65536, 18'sd65536, 18'sd65536);
        query(-32'sd65536, -32'sd65536, -32'sd65536, -18'sd65536, 18'sd0, 18'sd0);

        write_gains(24'd0, 24'd0);
        // displacement off and a null direction: zero vector
        query(rand_point(), rand_point(), rand_point(), 18'sd0, 18'sd0, 18'sd0);
        query(rand_point(), rand_point(), rand_point(), 18'sd1, 18'sd0, 18'sd0);
        query(32'sh7fffffff, 32'sh80000000, 32'sd5, 18'sh1ffff, 18'sh20000, 18'sd0);

        write_gains(24'hffffff, 24'h7fffff);
        query(32'sh7fffffff, 32'sh80000000, 32'sd12345, 18'sd0, 18'sd0, 18'sd0);
        query(32'sd70000, -32'sd70000, 32'sd1, 18'sd3, 18'sd3, 18'sd3);
        query(rand_point(), rand_point(), rand_point(), rand_dir(), rand_dir(),
              rand_dir());

        write_gains(24'd65536, 24'h800000);
        query(32'sd98304, 32'sd98304, 32'sd98304, 18'sd0, 18'sd0, 18'sd0);
        query(rand_point(), rand_point(), rand_point(), 18'sh1ffff, 18'sh20000,
              18'sd7);

        // long receiver hold-off while queries keep coming: input stalls
        hold_req = 1'b1;
        repeat (6) query(rand_point(), rand_point(), rand_point(), rand_dir(),
                         rand_dir(), rand_dir());
        // sender waits for every result before going on
        item_ch.valid <= 1'b0;
        wait (pending == 0);
        @(negedge i_clk);

        write_gains(24'($urandom_range(0, 4 << FRAC_BITS)),
                    24'(int'($urandom_range(0, 8 << FRAC_BITS)) - (4 << FRAC_BITS)));
        random_phase(130);
        write_gains(24'($urandom), 24'($urandom));
        random_phase(110);
        write_gains(24'($urandom_range(0, 2 << FRAC_BITS)),
                    24'(int'($urandom_range(0, 2 << FRAC_BITS)) - (1 << FRAC_BITS)));
        random_phase(110);

        // closing stretch with both sides flat out
        idle_on = 1'b0;
        write_gains(24'($urandom_range(1 << 12, 3 << FRAC_BITS)),
                    24'(int'($urandom_range(0, 6 << FRAC_BITS)) - (3 << FRAC_BITS)));
        random_phase(90);
        item_ch.valid <= 1'b0;

        wait (pending == 0);
        repeat (50) @(posedge i_clk);
        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
